### hdl/tts_pkg.sv
`default_nettype none
package tts_pkg;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned IDX_W  = 6;

    // Datapath operation codes
    typedef enum logic [2:0] {
        OP_MUL = 3'd0,
        OP_DIV = 3'd1,
        OP_SUB = 3'd2
    } t_op;

    // Operand source selects
    typedef enum logic [2:0] {
        SRC_IN_LO  = 3'd0,
        SRC_IN_DG  = 3'd1,
        SRC_IN_RH  = 3'd2,
        SRC_PIV    = 3'd3,
        SRC_RHS    = 3'd4,
        SRC_UPP    = 3'd5,
        SRC_SOL    = 3'd6,
        SRC_ACC    = 3'd7
    } t_src;

    // Destination of a finished operation
    typedef enum logic [2:0] {
        DST_ACC = 3'd0,
        DST_TMP = 3'd1,
        DST_PIV = 3'd2,
        DST_RHS = 3'd3,
        DST_SOL = 3'd4
    } t_dst;

    typedef struct packed {
        logic             start;     // launch one operation
        t_op              op;
        t_src             src_a;
        t_src             src_b;
        logic             b_is_tmp;  // take operand b from the temporary
        t_dst             dst;
        logic [IDX_W-1:0] rd_addr;   // memory read row
        logic             rd_en;
        logic [IDX_W-1:0] wr_addr;   // memory write row
        logic             load_row;  // latch the accepted input beat
        logic             wr_first;  // store row 0 directly
        logic             wr_upper;  // store the upper coefficient
        logic             fault_set;
        logic             fault_clr;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_stat;
endpackage
`default_nettype wire

### hdl/tts_if.sv
`default_nettype none
interface tts_row_if;
    logic        valid;
    logic        ready;
    logic [31:0] lower_coef;
    logic [31:0] diag_coef;
    logic [31:0] upper_coef;
    logic [31:0] rhs_value;
    logic        row_last;
    modport source (output valid, lower_coef, diag_coef, upper_coef, rhs_value, row_last,
                    input ready);
    modport sink   (input valid, lower_coef, diag_coef, upper_coef, rhs_value, row_last,
                    output ready);
endinterface

interface tts_sol_if;
    logic        valid;
    logic        ready;
    logic [31:0] solution_value;
    logic [5:0]  row_index;
    logic        result_last;
    logic        fault_flag;
    modport source (output valid, solution_value, row_index, result_last, fault_flag,
                    input ready);
    modport sink   (input valid, solution_value, row_index, result_last, fault_flag,
                    output ready);
endinterface
`default_nettype wire

### hdl/tts_datapath.sv
`default_nettype none
module tts_datapath
    import tts_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    input  wire logic [31:0]        i_lo,
    input  wire logic [31:0]        i_dg,
    input  wire logic [31:0]        i_up,
    input  wire logic [31:0]        i_rh,
    output t_stat                   o_stat,
    output logic [31:0]             o_sol,
    output logic                    o_fault
);
    localparam int unsigned NUM_W = 32 + FRAC_BITS + 1;
    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [31:0] r_piv_mem [64];
    logic [31:0] r_rhs_mem [64];
    logic [31:0] r_upp_mem [64];
    logic [31:0] r_sol_mem [64];
    logic [31:0] r_piv_q, r_rhs_q, r_upp_q, r_sol_q;
    logic [31:0] r_lo, r_dg, r_rh;
    logic [31:0] r_acc, r_tmp;
    logic        r_fault;

    // operation unit state
    logic             r_busy, r_done;
    t_op              r_op;
    t_dst             r_dst;
    logic             r_neg;
    logic [NUM_W-1:0] r_quo;
    logic [NUM_W:0]   r_rem;
    logic [NUM_W-1:0] r_num;
    logic [31:0]      r_den;
    logic [CNT_W-1:0] r_cnt;
    logic signed [63:0] r_prod;
    logic [31:0]      r_res;
    logic             r_sat;

    function automatic logic [31:0] pick(input t_src s, input logic [31:0] lo,
        input logic [31:0] dg, input logic [31:0] rh, input logic [31:0] pv,
        input logic [31:0] rs, input logic [31:0] up, input logic [31:0] so,
        input logic [31:0] ac);
        case (s)
            SRC_IN_LO: return lo;
            SRC_IN_DG: return dg;
            SRC_IN_RH: return rh;
            SRC_PIV:   return pv;
            SRC_RHS:   return rs;
            SRC_UPP:   return up;
            SRC_SOL:   return so;
            default:   return ac;
        endcase
    endfunction

    logic [31:0] w_a, w_b;
    assign w_a = pick(i_cmd.src_a, r_lo, r_dg, r_rh, r_piv_q, r_rhs_q, r_upp_q, r_sol_q, r_acc);
    assign w_b = i_cmd.b_is_tmp ? r_tmp :
        pick(i_cmd.src_b, r_lo, r_dg, r_rh, r_piv_q, r_rhs_q, r_upp_q, r_sol_q, r_acc);

    // restoring divider step
    logic [NUM_W:0] w_trial;
    logic [NUM_W:0] w_shift;
    assign w_shift = {r_rem[NUM_W-1:0], r_num[NUM_W-1]};
    assign w_trial = w_shift - {{(NUM_W-31){1'b0}}, r_den};

    // final saturation of divide and multiply
    logic signed [NUM_W:0] w_q_s;
    assign w_q_s = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    logic signed [63:0] w_mul_sh;
    assign w_mul_sh = r_prod >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_row) begin
            r_lo <= i_lo;
            r_dg <= i_dg;
            r_rh <= i_rh;
        end
        if (i_cmd.rd_en) begin
            r_piv_q <= r_piv_mem[i_cmd.rd_addr];
            r_rhs_q <= r_rhs_mem[i_cmd.rd_addr];
            r_upp_q <= r_upp_mem[i_cmd.rd_addr];
            r_sol_q <= r_sol_mem[i_cmd.rd_addr];
        end
        if (i_cmd.wr_upper) r_upp_mem[i_cmd.wr_addr] <= i_up;
        if (i_cmd.wr_first) begin
            r_piv_mem[i_cmd.wr_addr] <= i_dg;
            r_rhs_mem[i_cmd.wr_addr] <= i_rh;
        end
        if (r_done) begin
            case (r_dst)
                DST_ACC: r_acc <= r_res;
                DST_TMP: r_tmp <= r_res;
                DST_PIV: r_piv_mem[i_cmd.wr_addr] <= r_res;
                DST_RHS: r_rhs_mem[i_cmd.wr_addr] <= r_res;
                default: begin
                    r_sol_mem[i_cmd.wr_addr] <= r_res;
                    // keep the fresh solution for the row above
                    r_tmp <= r_res;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_fault <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.fault_clr) r_fault <= 1'b0;
            if (i_cmd.fault_set) r_fault <= 1'b1;
            if (r_done && r_sat) r_fault <= 1'b1;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_op   <= i_cmd.op;
                r_dst  <= i_cmd.dst;
                r_sat  <= 1'b0;
                case (i_cmd.op)
                    OP_MUL: r_prod <= $signed(w_a) * $signed(w_b);
                    OP_SUB: r_prod <= 64'($signed(w_a)) - 64'($signed(w_b));
                    default: begin
                        r_neg <= w_a[31] ^ w_b[31];
                        r_num <= NUM_W'(w_a[31] ? 32'(-w_a) : w_a) << FRAC_BITS;
                        r_den <= w_b[31] ? 32'(-w_b) : w_b;
                        r_rem <= '0;
                        r_quo <= '0;
                        r_cnt <= CNT_W'(NUM_W);
                        r_prod <= 64'($signed(w_b));
                    end
                endcase
            end else if (r_busy) begin
                case (r_op)
                    OP_MUL: begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                        if (w_mul_sh > 64'sh7FFF_FFFF) begin
                            r_res <= 32'h7FFF_FFFF; r_sat <= 1'b1;
                        end else if (w_mul_sh < -64'sh8000_0000) begin
                            r_res <= 32'h8000_0000; r_sat <= 1'b1;
                        end else r_res <= w_mul_sh[31:0];
                    end
                    OP_SUB: begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                        if (r_prod > 64'sh7FFF_FFFF) begin
                            r_res <= 32'h7FFF_FFFF; r_sat <= 1'b1;
                        end else if (r_prod < -64'sh8000_0000) begin
                            r_res <= 32'h8000_0000; r_sat <= 1'b1;
                        end else r_res <= r_prod[31:0];
                    end
                    default: begin
                        if (r_prod == 64'sd0) begin
                            // zero pivot gives zero and a fault
                            r_busy <= 1'b0; r_done <= 1'b1;
                            r_res <= '0; r_sat <= 1'b1;
                        end else if (r_cnt != '0) begin
                            r_cnt <= r_cnt - 1'b1;
                            r_num <= r_num << 1;
                            if (!w_trial[NUM_W]) begin
                                r_rem <= w_trial;
                                r_quo <= {r_quo[NUM_W-2:0], 1'b1};
                            end else begin
                                r_rem <= w_shift;
                                r_quo <= {r_quo[NUM_W-2:0], 1'b0};
                            end
                        end else begin
                            r_busy <= 1'b0; r_done <= 1'b1;
                            if (w_q_s > $signed({1'b0, NUM_W'(32'h7FFF_FFFF)})) begin
                                r_res <= 32'h7FFF_FFFF; r_sat <= 1'b1;
                            end else if (w_q_s < -$signed({1'b0, NUM_W'(32'h8000_0000)}))
                            begin
                                r_res <= 32'h8000_0000; r_sat <= 1'b1;
                            end else r_res <= w_q_s[31:0];
                        end
                    end
                endcase
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_sol   = r_sol_q;
    assign o_fault = r_fault || (r_done && r_sat);
endmodule
`default_nettype wire

### hdl/tts_ctrl.sv
`default_nettype none
module tts_ctrl
    import tts_pkg::*;
#(
    parameter int unsigned MAX_ROWS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_last,
    output logic             o_in_ready,
    input  wire t_stat       i_stat,
    output t_cmd             o_cmd,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [IDX_W-1:0] o_out_idx,
    output logic             o_out_last
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_RD    = 11'b00000000010,
        S_F_MU  = 11'b00000000100,
        S_F_DU  = 11'b00000001000,
        S_F_SP  = 11'b00000010000,
        S_F_MR  = 11'b00000100000,
        S_F_DR  = 11'b00001000000,
        S_F_SR  = 11'b00010000000,
        S_B_RD  = 11'b00100000000,
        S_B_OP  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state           r_state, n_state;
    logic [6:0]       r_cnt;    // rows stored
    logic [IDX_W-1:0] r_row, r_j;
    logic             r_last;
    logic [1:0]       r_step;   // back-substitution sub step
    logic             r_wait;   // an operation is in flight
    logic [IDX_W-1:0] r_oidx;
    logic             r_oval;

    logic w_acc;
    assign o_in_ready = (r_state == S_IDLE) && !r_oval;
    assign w_acc = i_in_valid && o_in_ready;

    logic w_go;  // launch when the unit is free
    assign w_go = !r_wait && !i_stat.busy;
    logic w_fin;
    assign w_fin = r_wait && i_stat.done;

    always_comb begin
        o_cmd = '0;
        o_cmd.op = OP_MUL;
        o_cmd.src_a = SRC_ACC;
        o_cmd.src_b = SRC_ACC;
        o_cmd.dst = DST_ACC;
        o_cmd.rd_addr = r_j;
        o_cmd.wr_addr = r_row;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    o_cmd.load_row = 1'b1;
                    o_cmd.rd_en = 1'b1;
                    o_cmd.rd_addr = IDX_W'(r_cnt - 7'd1);
                    o_cmd.wr_addr = r_cnt[IDX_W-1:0];
                    if (r_cnt >= 7'(MAX_ROWS)) begin
                        o_cmd.fault_set = 1'b1;
                        n_state = i_in_last ? S_B_RD : S_IDLE;
                    end else begin
                        o_cmd.wr_upper = 1'b1;
                        if (r_cnt == 7'd0) begin
                            o_cmd.wr_first = 1'b1;
                            n_state = i_in_last ? S_B_RD : S_IDLE;
                        end else n_state = S_RD;
                    end
                end
            end
            S_RD: n_state = S_F_MU;
            S_F_MU: begin
                o_cmd.start = w_go; o_cmd.op = OP_MUL;
                o_cmd.src_a = SRC_UPP; o_cmd.src_b = SRC_IN_LO; o_cmd.dst = DST_ACC;
                if (w_fin) n_state = S_F_DU;
            end
            S_F_DU: begin
                o_cmd.start = w_go; o_cmd.op = OP_DIV;
                o_cmd.src_a = SRC_ACC; o_cmd.src_b = SRC_PIV; o_cmd.dst = DST_TMP;
                if (w_fin) n_state = S_F_SP;
            end
            S_F_SP: begin
                o_cmd.start = w_go; o_cmd.op = OP_SUB;
                o_cmd.src_a = SRC_IN_DG; o_cmd.b_is_tmp = 1'b1; o_cmd.dst = DST_PIV;
                if (w_fin) n_state = S_F_MR;
            end
            S_F_MR: begin
                o_cmd.start = w_go; o_cmd.op = OP_MUL;
                o_cmd.src_a = SRC_RHS; o_cmd.src_b = SRC_IN_LO; o_cmd.dst = DST_ACC;
                if (w_fin) n_state = S_F_DR;
            end
            S_F_DR: begin
                o_cmd.start = w_go; o_cmd.op = OP_DIV;
                o_cmd.src_a = SRC_ACC; o_cmd.src_b = SRC_PIV; o_cmd.dst = DST_TMP;
                if (w_fin) n_state = S_F_SR;
            end
            S_F_SR: begin
                o_cmd.start = w_go; o_cmd.op = OP_SUB;
                o_cmd.src_a = SRC_IN_RH; o_cmd.b_is_tmp = 1'b1; o_cmd.dst = DST_RHS;
                if (w_fin) n_state = r_last ? S_B_RD : S_IDLE;
            end
            S_B_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state = S_B_OP;
            end
            S_B_OP: begin
                o_cmd.wr_addr = r_j;
                // last row: x = rhs/pivot; others: x = (rhs - upper*x[j+1])/pivot
                if (r_step == 2'd0) begin
                    o_cmd.start = w_go; o_cmd.op = OP_MUL;
                    o_cmd.src_a = SRC_UPP; o_cmd.b_is_tmp = 1'b1;
                end else if (r_step == 2'd1) begin
                    o_cmd.start = w_go; o_cmd.op = OP_SUB;
                    o_cmd.src_a = SRC_RHS; o_cmd.src_b = SRC_ACC;
                end else begin
                    o_cmd.start = w_go; o_cmd.op = OP_DIV;
                    o_cmd.src_a = (r_step == 2'd2) ? SRC_RHS : SRC_ACC;
                    o_cmd.src_b = SRC_PIV; o_cmd.dst = DST_SOL;
                end
                if (w_fin && o_cmd.dst == DST_SOL) begin
                    if (r_j == '0) n_state = S_OUT;
                    else n_state = S_B_RD;
                end
            end
            S_OUT: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.rd_addr = r_oidx;
                if (!r_oval || i_out_ready) begin
                    if (r_oval && o_out_last) begin
                        o_cmd.fault_clr = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    logic [IDX_W-1:0] w_n1;
    assign w_n1 = IDX_W'(r_cnt - 7'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_wait  <= 1'b0;
            r_oval  <= 1'b0;
            r_last  <= 1'b0;
            r_step  <= 2'd0;
        end else begin
            r_state <= n_state;
            if (o_cmd.start) r_wait <= 1'b1;
            if (w_fin) r_wait <= 1'b0;
            if (w_acc) begin
                r_last <= i_in_last;
                r_row  <= r_cnt[IDX_W-1:0];
                if (r_cnt < 7'(MAX_ROWS)) r_cnt <= r_cnt + 7'd1;
                r_j <= w_n1;
                if (r_cnt < 7'(MAX_ROWS)) r_j <= r_cnt[IDX_W-1:0];
                r_step <= 2'd2;
            end
            if (r_state == S_B_OP && w_fin) begin
                if (r_step == 2'd0) r_step <= 2'd1;
                else if (r_step == 2'd1) r_step <= 2'd3;
                else begin
                    r_step <= 2'd0;
                    r_j <= r_j - 1'b1;
                end
            end
            if (r_state != S_OUT && n_state == S_OUT) begin
                r_oidx <= '0;
                r_oval <= 1'b0;
            end
            if (r_state == S_OUT) begin
                if (!r_oval || i_out_ready) begin
                    if (r_oval && o_out_last) begin
                        r_oval <= 1'b0;
                        r_cnt  <= '0;
                    end else if (!r_oval) begin
                        // read data is in the register in the cycle after the address
                        r_oval <= r_step[1] ? 1'b0 : 1'b1;
                        r_step <= 2'd2;
                        if (r_step == 2'd2) r_step <= 2'd0;
                    end else begin
                        r_oval <= 1'b0;
                        r_oidx <= r_oidx + 1'b1;
                        r_step <= 2'd2;
                    end
                end
            end
        end
    end

    assign o_out_valid = r_oval;
    assign o_out_idx   = r_oidx;
    assign o_out_last  = (r_oidx == w_n1);
endmodule
`default_nettype wire

### hdl/tridiagonal_thomas_solver.sv
`default_nettype none
// Thomas-algorithm solver for one tridiagonal system in signed fixed point.
// Send rows in order, marking the last; results return in row order with the
// last one marked and a fault flag common to the whole system. Each row's
// elimination runs two divisions on one shared bit-serial divider; the
// back-substitution then follows, and each result is held until the
// receiver takes it with ready high.
module tridiagonal_thomas_solver
    import tts_pkg::*;
#(
    parameter int unsigned MAX_ROWS  = 64,
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tts_row_if.sink   i_row,
    tts_sol_if.source o_sol
);
    t_cmd  w_cmd;
    t_stat w_stat;
    logic [31:0] w_sol;
    logic w_fault;

    tts_ctrl #(.MAX_ROWS(MAX_ROWS)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid (i_row.valid),
        .i_in_last  (i_row.row_last),
        .o_in_ready (i_row.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_out_valid(o_sol.valid),
        .i_out_ready(o_sol.ready),
        .o_out_idx  (o_sol.row_index),
        .o_out_last (o_sol.result_last)
    );

    tts_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk, .i_rst_n,
        .i_cmd  (w_cmd),
        .i_lo   (i_row.lower_coef),
        .i_dg   (i_row.diag_coef),
        .i_up   (i_row.upper_coef),
        .i_rh   (i_row.rhs_value),
        .o_stat (w_stat),
        .o_sol  (w_sol),
        .o_fault(w_fault)
    );

    assign o_sol.solution_value = w_sol;
    assign o_sol.fault_flag     = w_fault;
endmodule
`default_nettype wire

### verif/tridiagonal_thomas_solver_tb.sv
module tridiagonal_thomas_solver_tb;
    import tts_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ROWS_MAX = 64;
    localparam int unsigned FRAC     = 16;
    localparam longint S32_HI = 64'sd2147483647;
    localparam longint S32_LO = -64'sd2147483648;

    typedef struct {
        logic [31:0] lower;
        logic [31:0] diag;
        logic [31:0] upper;
        logic [31:0] rhs;
        logic        last;
        logic        has_known;   // first result typed in below
        logic [31:0] known_value;
        logic        known_fault;
    } t_row_vec;

    typedef struct packed {
        logic [31:0] value;
        logic [5:0]  index;
        logic        last;
        logic        fault;
    } t_sol;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tts_row_if row_bus ();
    tts_sol_if sol_bus ();

    tridiagonal_thomas_solver i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_row  (row_bus.sink),
        .o_sol  (sol_bus.source)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    logic signed [31:0] piv_q [ROWS_MAX];
    logic signed [31:0] rhs_q [ROWS_MAX];
    logic signed [31:0] upp_q [ROWS_MAX];
    logic signed [31:0] sol_q [ROWS_MAX];
    int unsigned rows_held;
    bit          sys_fault;

    t_sol solutions_due[$];
    int   errors;
    bit   hold_sink;
    int   rows_sent;

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > S32_HI) begin
            sys_fault = 1'b1;
            return S32_HI[31:0];
        end
        if (v < S32_LO) begin
            sys_fault = 1'b1;
            return S32_LO[31:0];
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] q_mul(logic signed [31:0] x,
                                                  logic signed [31:0] y);
        longint p;
        p = longint'(x) * longint'(y);
        return clamp32(p >>> FRAC);   // arithmetic shift floors
    endfunction

    function automatic logic signed [31:0] q_div(logic signed [31:0] n,
                                                  logic signed [31:0] d);
        longint num;
        if (d == 0) begin
            sys_fault = 1'b1;
            return '0;
        end
        num = longint'(n) <<< FRAC;
        return clamp32(num / longint'(d));
    endfunction

    function automatic logic signed [31:0] q_sub(logic signed [31:0] x,
                                                  logic signed [31:0] y);
        return clamp32(longint'(x) - longint'(y));
    endfunction

    task automatic eliminate_row(input t_row_vec r);
        int unsigned j;
        logic signed [31:0] pp;
        t_sol s;
        if (rows_held >= ROWS_MAX) begin
            sys_fault = 1'b1;
        end else begin
            j = rows_held;
            if (j == 0) begin
                piv_q[0] = r.diag;
                rhs_q[0] = r.rhs;
            end else begin
                pp = piv_q[j-1];
                piv_q[j] = q_sub(r.diag, q_div(q_mul(upp_q[j-1], r.lower), pp));
                rhs_q[j] = q_sub(r.rhs, q_div(q_mul(rhs_q[j-1], r.lower), pp));
            end
            upp_q[j] = r.upper;
            rows_held = j + 1;
        end
        if (!r.last) return;
        sol_q[rows_held-1] = q_div(rhs_q[rows_held-1], piv_q[rows_held-1]);
        for (int k = rows_held - 1; k > 0; k--)
            sol_q[k-1] = q_div(q_sub(rhs_q[k-1], q_mul(upp_q[k-1], sol_q[k])), piv_q[k-1]);
        for (int k = 0; k < rows_held; k++) begin
            s.value = sol_q[k];
            s.index = k[5:0];
            s.last  = (k + 1 == rows_held);
            s.fault = sys_fault;
            solutions_due.push_back(s);
        end
        rows_held = 0;
        sys_fault = 1'b0;
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rand_coef();
        int p;
        p = $urandom_range(0, 9);
        case (p)
            0: begin
                return $urandom();
            end
            1: begin
                return 32'h8000_0000;
            end
            2: begin
                return 32'h7fff_ffff;
            end
            3: begin
                return '0;
            end
            default: begin
                return 32'(int'($urandom_range(0, 8 << 16)) - (4 << 16));
            end
        endcase
    endfunction

    task automatic send_row(input t_row_vec r);
        int g;
        g = gap_len();
        // drop valid over the gap, keep it high for a beat that follows at once
        if (g > 0) begin
            row_bus.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        row_bus.valid      <= 1'b1;
        row_bus.lower_coef <= r.lower;
        row_bus.diag_coef  <= r.diag;
        row_bus.upper_coef <= r.upper;
        row_bus.rhs_value  <= r.rhs;
        row_bus.row_last   <= r.last;
        do @(posedge i_clk); while (!row_bus.ready);
        rows_sent++;
        if (r.has_known && rows_held == 0) begin
            // typed-in check of the only result of a one-row system
            eliminate_row(r);
            if (solutions_due[$].value !== r.known_value ||
                solutions_due[$].fault !== r.known_fault) begin
                $display("%t table row: expected %h/%b, predicted %h/%b", $time,
                         r.known_value, r.known_fault,
                         solutions_due[$].value, solutions_due[$].fault);
                errors++;
            end
        end else begin
            eliminate_row(r);
        end
    endtask

    function automatic t_row_vec mk(logic [31:0] lo, logic [31:0] dg, logic [31:0] up,
                                    logic [31:0] rh, logic lst);
        t_row_vec r;
        r.lower = lo; r.diag = dg; r.upper = up; r.rhs = rh; r.last = lst;
        r.has_known = 1'b0; r.known_value = '0; r.known_fault = 1'b0;
        return r;
    endfunction

    function automatic t_row_vec mk_known(logic [31:0] dg, logic [31:0] rh,
                                          logic [31:0] v, logic f);
        t_row_vec r;
        r = mk(32'hdead_beef, dg, 32'h1234_5678, rh, 1'b1);
        r.has_known = 1'b1; r.known_value = v; r.known_fault = f;
        return r;
    endfunction

    task automatic wait_drain();
        row_bus.valid <= 1'b0;
        while (solutions_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_system(input int n, input bit dominant);
        t_row_vec r;
        for (int i = 0; i < n; i++) begin
            if (dominant) begin
                r = mk(32'(int'($urandom_range(0, 2 << 16)) - (1 << 16)),
                       32'(int'($urandom_range(3 << 16, 6 << 16)) *
                           ($urandom_range(0, 1) ? 1 : -1)),
                       32'(int'($urandom_range(0, 2 << 16)) - (1 << 16)),
                       $urandom(), i == n - 1);
            end else begin
                r = mk(rand_coef(), rand_coef(), rand_coef(), rand_coef(), i == n - 1);
            end
            send_row(r);
        end
    endtask

    // result side
    always @(posedge i_clk) begin
        t_sol got;
        t_sol exp_s;
        if (!i_rst_n) begin
            sol_bus.ready <= 1'b0;
        end else begin
            if (sol_bus.valid && sol_bus.ready) begin
                got = '{sol_bus.solution_value, sol_bus.row_index,
                        sol_bus.result_last, sol_bus.fault_flag};
                if (solutions_due.size() == 0) begin
                    $display("%t unexpected solution beat %p", $time, got);
                    errors++;
                end else begin
                    exp_s = solutions_due.pop_front();
                    if (got.value !== exp_s.value)
                        $display("%t value: expected %h, actual %h", $time,
                                 exp_s.value, got.value);
                    if (got.index !== exp_s.index)
                        $display("%t row_index: expected %0d, actual %0d", $time,
                                 exp_s.index, got.index);
                    if (got.last !== exp_s.last)
                        $display("%t result_last: expected %b, actual %b", $time,
                                 exp_s.last, got.last);
                    if (got.fault !== exp_s.fault)
                        $display("%t fault_flag: expected %b, actual %b", $time,
                                 exp_s.fault, got.fault);
                    if (got !== exp_s) errors++;
                end
            end
            sol_bus.ready <= !hold_sink && ($urandom_range(0, 9) < 7);
        end
    end

    // long receiver hold-off, counted here
    initial begin
        hold_sink = 1'b0;
        wait (i_rst_n);
        repeat (3000) @(posedge i_clk);
        hold_sink = 1'b1;
        repeat (40000) @(posedge i_clk);
        hold_sink = 1'b0;
    end

    initial begin
        #80ms;
        $display("tridiagonal_thomas_solver: mismatch");
        $finish;
    end

    initial begin
        t_row_vec tbl[$];
        row_bus.valid      = 1'b0;
        row_bus.lower_coef = '0;
        row_bus.diag_coef  = '0;
        row_bus.upper_coef = '0;
        row_bus.rhs_value  = '0;
        row_bus.row_last   = 1'b0;
        errors = 0;
        rows_held = 0;
        rows_sent = 0;
        sys_fault = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // one-row systems: x = rhs / diag
        tbl.push_back(mk_known(32'h0001_0000, 32'h0003_0000, 32'h0003_0000, 1'b0));
        tbl.push_back(mk_known(32'h0000_0000, 32'h0005_0000, 32'h0000_0000, 1'b1));
        tbl.push_back(mk_known(32'h0000_0001, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1));
        tbl.push_back(mk_known(32'h0000_0001, 32'h8000_0000, 32'h8000_0000, 1'b1));
        tbl.push_back(mk_known(32'hffff_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b1));
        tbl.push_back(mk_known(32'h0002_0000, 32'hffff_0000, 32'hffff_8000, 1'b0));
        // small systems, extremes of every field
        tbl.push_back(mk(32'h8000_0000, 32'h0004_0000, 32'h0001_0000, 32'h0002_0000, 0));
        tbl.push_back(mk(32'h0001_0000, 32'h0004_0000, 32'h0001_0000, 32'h0006_0000, 0));
        tbl.push_back(mk(32'h0001_0000, 32'h0004_0000, 32'hffff_ffff, 32'hfffe_0000, 1));
        tbl.push_back(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0));
        tbl.push_back(mk(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1));
        tbl.push_back(mk(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 0));
        tbl.push_back(mk(32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 32'h0001_0000, 1));
        tbl.push_back(mk(32'hffff_ffff, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0));
        tbl.push_back(mk(32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1));
        foreach (tbl[i]) send_row(tbl[i]);
        wait_drain();

        // overflow: MAX_ROWS rows then extra rows, the last one marked
        for (int i = 0; i < ROWS_MAX + 2; i++)
            send_row(mk(32'h0000_8000, 32'h0004_0000, 32'h0000_8000, $urandom(),
                        i == ROWS_MAX + 1));
        // full system exactly MAX_ROWS with last on the final row
        random_system(ROWS_MAX, 1'b1);
        wait_drain();

        while (rows_sent < 190) begin
            random_system($urandom_range(1, 6), $urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0) wait_drain();
        end
        repeat (40) random_system(1, $urandom_range(0, 1));

        wait_drain();
        repeat (500) @(posedge i_clk);
        if (errors == 0)
            $display("tridiagonal_thomas_solver: match");
        else
            $display("tridiagonal_thomas_solver: mismatch");
        $finish;
    end
endmodule
